FILE: hw/rtl/plarb_pkg.sv
package plarb_pkg;

  // Default sizes of the waiter store.
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int PRIO_BITS_DEF   = 8;

  // Field widths fixed by the item formats.
  localparam int ID_W      = 4;
  localparam int PRIO_W    = 8;
  localparam int WAITING_W = 5;
  localparam int STATUS_W  = 2;

  // Item kinds carried in the mode field.
  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REL_FREE = 2'd2;

  // One input item.
  typedef struct packed {
    logic              mode;
    logic [ID_W-1:0]   requester;
    logic [PRIO_W-1:0] priority_req;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic                 grant_valid;
    logic [ID_W-1:0]      grant_id;
    logic [PRIO_W-1:0]    grant_priority;
    logic                 held;
    logic [WAITING_W-1:0] waiting;
    logic [STATUS_W-1:0]  status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

FILE: hw/rtl/plarb_ctrl.sv
module plarb_ctrl
  import plarb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r == ST_EXEC);

endmodule

FILE: hw/rtl/plarb_dpath.sv
module plarb_dpath
  import plarb_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int PRIO_BITS   = PRIO_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int EW  = (PRIO_BITS > PRIO_W) ? PRIO_BITS : PRIO_W;
  localparam int CEW = (CW > WAITING_W) ? CW : WAITING_W;

  // Captured item.
  in_item_t in_r;

  // Waiter cells, kept sorted by priority, oldest first among equals.
  logic [PRIO_BITS-1:0] prio_r [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0] prio_nxt [QUEUE_DEPTH];
  logic [ID_W-1:0]      id_r [QUEUE_DEPTH];
  logic [ID_W-1:0]      id_nxt [QUEUE_DEPTH];
  logic [CW-1:0]        count_r, count_nxt;
  logic                 held_r, held_nxt;

  logic                 out_valid_r;
  out_item_t            out_r, out_nxt;

  logic [EW-1:0]        new_ext;
  logic [PRIO_BITS-1:0] new_prio;
  logic [EW-1:0]        grant_ext;
  logic [EW-1:0]        head_ext;
  logic [CEW-1:0]       count_ext;
  logic [QUEUE_DEPTH-1:0] ge;
  logic                 do_insert;
  logic                 do_pop;

  // The new priority keeps only its low PRIO_BITS bits.
  assign new_ext   = EW'(in_r.priority_req);
  assign new_prio  = new_ext[PRIO_BITS-1:0];
  assign grant_ext = EW'(new_prio);
  assign head_ext  = EW'(prio_r[0]);

  // Cells whose waiter stays ahead of the new request.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge[i] = (CW'(i) < count_r) && (prio_r[i] >= new_prio);
    end
  end

  // Item decode and result.
  always_comb begin
    held_nxt  = held_r;
    count_nxt = count_r;
    do_insert = 1'b0;
    do_pop    = 1'b0;
    out_nxt   = '0;
    unique case (in_r.mode)
      MODE_REQUEST: begin
        if (!held_r) begin
          held_nxt               = 1'b1;
          out_nxt.grant_valid    = 1'b1;
          out_nxt.grant_id       = in_r.requester;
          out_nxt.grant_priority = grant_ext[PRIO_W-1:0];
        end else if (count_r == CW'(QUEUE_DEPTH)) begin
          out_nxt.status = STAT_FULL;
        end else begin
          do_insert = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      MODE_RELEASE: begin
        if (!held_r) begin
          out_nxt.status = STAT_REL_FREE;
        end else if (count_r == '0) begin
          held_nxt = 1'b0;
        end else begin
          do_pop                 = 1'b1;
          count_nxt              = count_r - CW'(1);
          out_nxt.grant_valid    = 1'b1;
          out_nxt.grant_id       = id_r[0];
          out_nxt.grant_priority = head_ext[PRIO_W-1:0];
        end
      end
      default: begin
        out_nxt = '0;
      end
    endcase
    count_ext       = CEW'(count_nxt);
    out_nxt.held    = held_nxt;
    out_nxt.waiting = count_ext[WAITING_W-1:0];
  end

  // Each cell keeps its value, takes the new request, shifts down on insert
  // or shifts up on pop.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      prio_nxt[i] = prio_r[i];
      id_nxt[i]   = id_r[i];
      if (do_insert && !ge[i]) begin
        if (i == 0) begin
          prio_nxt[i] = new_prio;
          id_nxt[i]   = in_r.requester;
        end else if (ge[(i == 0) ? 0 : i - 1]) begin
          prio_nxt[i] = new_prio;
          id_nxt[i]   = in_r.requester;
        end else begin
          prio_nxt[i] = prio_r[(i == 0) ? 0 : i - 1];
          id_nxt[i]   = id_r[(i == 0) ? 0 : i - 1];
        end
      end else if (do_pop && (i < QUEUE_DEPTH - 1)) begin
        prio_nxt[i] = prio_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        id_nxt[i]   = id_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.execute;
      if (cmd.execute) begin
        held_r  <= held_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.execute) begin
      out_r <= out_nxt;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        prio_r[i] <= prio_nxt[i];
        id_r[i]   <= id_nxt[i];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hw/rtl/priority_lock_arbiter_core.sv
// Channel  | Ports                       | Transfer
// ---------+-----------------------------+------------------------------------
// input    | start, busy, in_data        | rising edge with start high, busy low
// result   | out_valid, out_data         | rising edge ending the out_valid cycle
//
// Each item is first captured, and then the waiter cells insert or pop in
// parallel; its result shows on out_valid in the cycle after that step,
// while the next item may already be captured.
// Reset (rst_n low at a clock edge) frees the lock and empties the store.
// The receiver cannot stall; every result is shown for exactly one cycle.
module priority_lock_arbiter_core
  import plarb_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int PRIO_BITS   = PRIO_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  dp_cmd_t cmd;

  // Sequencer.
  plarb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Lock state and waiter cells.
  plarb_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PRIO_BITS   (PRIO_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: test/tb_priority_lock_arbiter_core.sv
module tb_priority_lock_arbiter_core;
  import plarb_pkg::*;

  // Predicts the grant result of every accepted item and checks the block against it.
  class lock_grant_model;
    typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
    } waiter_t;

    bit          lock_held;
    waiter_t     waiters[$];
    out_item_t   grants_due[$];
    int unsigned mismatches;

    // Apply one accepted item to the predicted lock state and queue its result.
    function void take_item(in_item_t item);
      out_item_t r;
      waiter_t   w;
      int        best;
      r = '0;
      r.status = STAT_OK;
      if (item.mode == MODE_REQUEST) begin
        if (!lock_held) begin
          lock_held = 1'b1;
          r.grant_valid = 1'b1;
          r.grant_id = item.requester;
          r.grant_priority = item.priority_req;
        end else if (waiters.size() >= QUEUE_DEPTH_DEF) begin
          r.status = STAT_FULL;
        end else begin
          w.id = item.requester;
          w.prio = item.priority_req;
          waiters.push_back(w);
        end
      end else if (!lock_held) begin
        r.status = STAT_REL_FREE;
      end else if (waiters.size() == 0) begin
        lock_held = 1'b0;
      end else begin
        // Highest priority wins; the strict compare keeps the oldest among equals.
        best = 0;
        for (int i = 1; i < waiters.size(); i++) begin
          if (waiters[i].prio > waiters[best].prio) best = i;
        end
        r.grant_valid = 1'b1;
        r.grant_id = waiters[best].id;
        r.grant_priority = waiters[best].prio;
        waiters.delete(best);
      end
      r.held = lock_held;
      r.waiting = WAITING_W'(waiters.size());
      grants_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Check one result transfer against the oldest pending prediction.
    function void check_grant(out_item_t got);
      out_item_t want;
      if (grants_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = grants_due.pop_front();
      compare_field("grant_valid", 16'(want.grant_valid), 16'(got.grant_valid));
      compare_field("grant_id", 16'(want.grant_id), 16'(got.grant_id));
      compare_field("grant_priority", 16'(want.grant_priority), 16'(got.grant_priority));
      compare_field("held", 16'(want.held), 16'(got.held));
      compare_field("waiting", 16'(want.waiting), 16'(got.waiting));
      compare_field("status", 16'(want.status), 16'(got.status));
    endfunction

    function int unsigned pending();
      return grants_due.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  lock_grant_model book;

  priority_lock_arbiter_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watch both channels; an input transfer is noted before the result of the same edge.
  always @(posedge clk) begin
    if (rst_n && start && !busy) book.take_item(in_data);
    if (rst_n && out_valid) book.check_grant(out_data);
  end

  function automatic in_item_t mk_item(logic mode, int unsigned id, int unsigned prio);
    in_item_t item;
    item.mode = mode;
    item.requester = ID_W'(id);
    item.priority_req = PRIO_W'(prio);
    return item;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // Narrow priorities crowd onto a few values so that ties are common.
  function automatic in_item_t random_item(int unsigned req_pct, bit narrow);
    logic mode;
    int unsigned prio;
    mode = ($urandom_range(99) < req_pct) ? MODE_REQUEST : MODE_RELEASE;
    if (!narrow) prio = $urandom_range(255);
    else if ($urandom_range(1)) prio = $urandom_range(3);
    else prio = 255 - $urandom_range(1);
    return mk_item(mode, $urandom_range(15), prio);
  endfunction

  // Offer one item after an idle gap and hold it until the transfer happens.
  task automatic send_item(in_item_t item, int unsigned gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
      in_data <= in_item_t'($urandom);
    end
    @(negedge clk);
    start <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending until every predicted result has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned count, int unsigned req_pct, bit narrow, bit idle);
    repeat (count) send_item(random_item(req_pct, narrow), idle ? gap_len() : 0);
    drain();
  endtask

  // Directed corner cases: release while free, fill to full, ties on release.
  task automatic directed_items();
    int unsigned prio;
    send_item(mk_item(MODE_RELEASE, 15, 255), 0);
    send_item(mk_item(MODE_REQUEST, 0, 0), 0);
    send_item(mk_item(MODE_RELEASE, 15, 255), 1);
    send_item(mk_item(MODE_REQUEST, 15, 255), 0);
    for (int i = 0; i < QUEUE_DEPTH_DEF; i++) begin
      case (i % 4)
        0: prio = 8'h80;
        1: prio = 8'hFF;
        2: prio = 8'h00;
        default: prio = 8'h80;
      endcase
      send_item(mk_item(MODE_REQUEST, i, prio), i % 3);
    end
    send_item(mk_item(MODE_REQUEST, 7, 8'hAA), 0);
    repeat (4) send_item(mk_item(MODE_RELEASE, $urandom_range(15), $urandom_range(255)), 0);
    drain();
  endtask

  initial begin
    book = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_items();
    run_phase(200, 55, 1'b0, 1'b1);
    run_phase(250, 80, 1'b1, 1'b1);
    run_phase(200, 30, 1'b0, 1'b0);
    run_phase(300, 50, 1'b1, 1'b1);
    run_phase(250, 90, 1'b0, 1'b0);
    run_phase(200, 20, 1'b1, 1'b1);
    run_phase(275, 60, 1'b0, 1'b1);

    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("tb_priority_lock_arbiter_core passed");
    end else begin
      $display("tb_priority_lock_arbiter_core failed");
    end
    $finish;
  end

  // Run limit well above the slowest legal run.
  initial begin
    #5000000;
    $display("tb_priority_lock_arbiter_core failed");
    $finish;
  end

endmodule
